// ----- rtl/prime_sieve_filter_chain_unit_macros.svh -----
// Assertion macros shared by the checker of the prime sieve filter chain unit.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef PRIME_SIEVE_FILTER_CHAIN_UNIT_MACROS_SVH
`define PRIME_SIEVE_FILTER_CHAIN_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSF_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("prime sieve check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("prime sieve check failed");

`endif

// ----- rtl/psf_pkg.sv -----
// Package of the prime sieve filter chain unit: sizes, item types and the
// control types between the top level and the remainder unit. No dependencies.
`default_nettype none

package psf_pkg;

   localparam int CELLS       = 16;
   localparam int VALUE_WIDTH = 16;
   localparam int CNT_W       = $clog2(CELLS + 1);
   localparam int IDX_W       = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int STEP_W      = $clog2(VALUE_WIDTH);

   typedef struct packed {
      logic [15:0] candidate;
      logic        run_end;
   } req_type;

   typedef struct packed {
      logic [15:0] prime_value;
      logic [3:0]  cell_index;
      logic        chain_overflow;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_res_type;

endpackage

`default_nettype wire

// ----- rtl/psf_rem.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on psf_pkg for the value width and the command and result types.
`default_nettype none

module psf_rem (
   input  logic                clock,
   input  logic                reset,
   input  psf_pkg::rem_cmd_type cmd,
   output psf_pkg::rem_res_type res
);
   import psf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH-1:0] rem_step;

   assign trial    = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign rem_step = (trial >= {1'b0, dsr_ff}) ? diff[VALUE_WIDTH-1:0]
                                                : trial[VALUE_WIDTH-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = STEP_W'(cnt_ff + 1'b1);
         if (cnt_ff == STEP_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign res.done = done_ff;
   assign res.zero = (rem_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/prime_sieve_filter_chain_unit.sv -----
// Prime sieve filter chain unit: the top level with the prime memory and sequencer.
// Depends on psf_pkg and on psf_rem for the trial divisions.
//
// The unit takes one candidate at a time and tests it against the stored primes,
// which sit in a synchronous memory with one read and one write port, in the
// order they were found. Each test is a remainder computed by the shared
// bit-serial unit, one bit per cycle; per stored prime the sequencer reads it,
// loads it into that unit and waits for the remainder; a candidate below two
// is dropped as it is accepted. A survivor is written to the next free cell and
// reported; with every cell full it is reported with the overflow flag and not
// stored. A result sits in an output register, so the next item is accepted
// while it waits. run_end empties the chain after its item, and no clearing pass
// is needed after reset.
`default_nettype none

module prime_sieve_filter_chain_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psf_pkg::rsp_type rsp_data
);
   import psf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       filled_ff, filled_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic [VALUE_WIDTH-1:0] mem_primes [CELLS];
   logic                   mem_we;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;

   logic [31:0]            cand_ext;
   logic [31:0]            out_ext;
   logic [31:0]            filled_ext;
   logic [VALUE_WIDTH-1:0] req_value;
   logic [CNT_W-1:0]       idx_next;
   logic                   out_free;
   logic                   chain_full;

   rem_cmd_type            rem_cmd;
   rem_res_type            rem_res;

   psf_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .res   (rem_res)
   );

   assign cand_ext   = 32'(req_data.candidate);
   assign req_value  = cand_ext[VALUE_WIDTH-1:0];
   assign out_ext    = 32'(cand_ff);
   assign filled_ext = 32'(filled_ff);
   assign idx_next   = CNT_W'(idx_ff + 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign chain_full = (filled_ff == CNT_W'(CELLS));
   assign rd_addr    = idx_ff[IDX_W-1:0];
   assign wr_addr    = filled_ff[IDX_W-1:0];

   always_comb begin
      state_in         = state_ff;
      cand_in          = cand_ff;
      last_in          = last_ff;
      idx_in           = idx_ff;
      filled_in        = filled_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      mem_we           = 1'b0;
      rem_cmd.start    = 1'b0;
      rem_cmd.dividend = cand_ff;
      rem_cmd.divisor  = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cand_in = req_value;
               last_in = req_data.run_end;
               idx_in  = '0;
               if (req_value < VALUE_WIDTH'(2)) begin
                  if (req_data.run_end) begin
                     filled_in = '0;
                  end
               end else if (filled_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_cmd.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (rem_res.done) begin
               if (rem_res.zero) begin
                  if (last_ff) begin
                     filled_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_next;
                  if (idx_next == filled_ff) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.prime_value = out_ext[15:0];
               if (chain_full) begin
                  rsp_data_in.cell_index     = '0;
                  rsp_data_in.chain_overflow = 1'b1;
               end else begin
                  mem_we                     = 1'b1;
                  filled_in                  = CNT_W'(filled_ff + 1'b1);
                  rsp_data_in.cell_index     = filled_ext[3:0];
                  rsp_data_in.chain_overflow = 1'b0;
               end
               if (last_ff) begin
                  filled_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff     <= cand_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_primes[wr_addr] <= cand_ff;
      end
      rd_data_ff <= mem_primes[rd_addr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/psf_checker.sv -----
// Port-level checker of the prime sieve filter chain unit and its bind statement.
// Depends on psf_pkg and on the assertion macros header.
`default_nettype none
`include "prime_sieve_filter_chain_unit_macros.svh"

module psf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input psf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input psf_pkg::rsp_type rsp_data
);
   import psf_pkg::*;

   // A result that is not taken stays on the port unchanged.
   `PSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // An overflowing item was never stored, so it names no cell.
   `PSF_ASSERT_NOW(a_overflow_cell, clock, reset, rsp_valid && rsp_data.chain_overflow, rsp_data.cell_index == 4'd0)

   // A reported prime is never below two.
   `PSF_ASSERT_NOW(a_prime_min, clock, reset, rsp_valid, rsp_data.prime_value[15:1] != 15'd0)

   // A new result only appears while an item is at work.
   `PSF_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind prime_sieve_filter_chain_unit psf_checker u_psf_checker (.*);

`default_nettype wire

// ----- tb/sv/psf_sieve_checker.sv -----
// Checker for the prime sieve filter chain unit: watches both channels, predicts each
// result from its own copy of the prime chain and compares field by field.
// Depends on psf_pkg for the item types and sizes.
`timescale 1ns / 1ps

module psf_sieve_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  psf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  psf_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               result_count,
   output int               overflow_count
);
   import psf_pkg::*;

   localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;

   int unsigned prime_chain [CELLS];
   int unsigned chain_fill;
   rsp_type     expected_primes [$];

   function automatic void sieve_next(input req_type item, output bit survived,
                                      output rsp_type prime_out);
      int unsigned value;
      int unsigned idx;
      bit          divided;
      value     = int'(longint'(item.candidate) & VALUE_MASK);
      divided   = 1'b0;
      survived  = 1'b0;
      prime_out = '0;
      if (value >= 2) begin
         for (idx = 0; idx < chain_fill && idx < CELLS; idx++) begin
            if (prime_chain[idx] != 0 && value % prime_chain[idx] == 0) begin
               divided = 1'b1;
            end
         end
         if (!divided) begin
            survived = 1'b1;
            prime_out.prime_value = value[15:0];
            if (chain_fill < CELLS) begin
               prime_chain[chain_fill] = value;
               prime_out.cell_index = chain_fill[3:0];
               chain_fill++;
            end else begin
               prime_out.chain_overflow = 1'b1;
            end
         end
      end
      if (item.run_end) begin
         chain_fill = 0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      bit      survived;
      if (reset) begin
         chain_fill     = 0;
         fail_count     = 0;
         result_count   = 0;
         overflow_count = 0;
         expected_primes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            result_count++;
            if (got.chain_overflow) begin
               overflow_count++;
            end
            if (expected_primes.size() == 0) begin
               $display("%0t: unexpected item: prime_value=%0d cell_index=%0d overflow=%0d",
                        $time, got.prime_value, got.cell_index, got.chain_overflow);
               fail_count++;
            end else begin
               want = expected_primes.pop_front();
               if (got.prime_value !== want.prime_value) begin
                  $display("%0t: prime_value expected %0d actual %0d",
                           $time, want.prime_value, got.prime_value);
                  fail_count++;
               end
               if (got.cell_index !== want.cell_index) begin
                  $display("%0t: cell_index expected %0d actual %0d",
                           $time, want.cell_index, got.cell_index);
                  fail_count++;
               end
               if (got.chain_overflow !== want.chain_overflow) begin
                  $display("%0t: chain_overflow expected %0d actual %0d",
                           $time, want.chain_overflow, got.chain_overflow);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            sieve_next(req_data, survived, want);
            if (survived) begin
               expected_primes.push_back(want);
            end
         end
      end
      pending = expected_primes.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the prime sieve filter chain testbench: clock, reset, candidate stimulus,
// receiver back-pressure and the verdict. Depends on psf_pkg, psf_sieve_checker
// and prime_sieve_filter_chain_unit.
`timescale 1ns / 1ps

module tb;
   import psf_pkg::*;

   localparam int CYCLE_LIMIT    = 3000000;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int HOLD_POINT     = 400;
   localparam int HOLD_CYCLES    = 400;
   localparam int PAUSE_POINT    = 900;
   localparam int DRAIN_CYCLES   = 320;
   localparam int DIRECTED_COUNT = 24;
   localparam int unsigned DIRECTED [DIRECTED_COUNT] = '{
      0, 1, 65535, 65521, 65535, 1,
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
      59, 4
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int result_count;
   int overflow_count;
   int cycle_count;
   int sent_count;
   int offered_count;
   int holds_issued;
   bit drained;
   bit hold_request;

   prime_sieve_filter_chain_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   psf_sieve_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .result_count   (result_count),
      .overflow_count (overflow_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic offer_candidate(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
      if (item.candidate >= 2) begin
         offered_count++;
      end
      if (holds_issued < 2 && offered_count >= HOLD_POINT * (holds_issued + 1)) begin
         hold_request = 1'b1;
         holds_issued++;
      end
      if (!drained && offered_count >= PAUSE_POINT) begin
         drained = 1'b1;
         req_valid <= 1'b0;
         do @(negedge clock); while (pending != 0);
      end
   endtask

   initial begin
      int len;
      int g;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            len = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
            repeat (len) @(negedge clock);
            g = pick_gap();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   initial begin
      req_type     item;
      int unsigned cand;
      int          run_len;
      int          k;
      int          r;
      bit          end_mark;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      sent_count    = 0;
      offered_count = 0;
      holds_issued  = 0;
      drained       = 1'b0;
      hold_request  = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < DIRECTED_COUNT; k++) begin
         item.candidate = DIRECTED[k][15:0];
         item.run_end   = (k == 5) || (k == DIRECTED_COUNT - 1);
         offer_candidate(item);
      end

      while (offered_count < DIRECTED_COUNT + RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 80) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               cand = $urandom_range(0, 3);
            end else if (r < 85) begin
               cand = $urandom_range(4, 2000);
            end else begin
               cand = $urandom_range(60000, 65535);
            end
            run_len  = $urandom_range(10, 90);
            end_mark = ($urandom_range(0, 14) != 0);
            for (k = 0; k < run_len && cand <= 65535; k++) begin
               item.candidate = cand[15:0];
               item.run_end   = end_mark && (k == run_len - 1);
               if ($urandom_range(0, 39) == 0) begin
                  item.candidate = 16'($urandom_range(0, cand));
               end
               offer_candidate(item);
               cand += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
            end
         end else begin
            if ($urandom_range(0, 99) < 20) begin
               item.candidate = 16'($urandom_range(0, 1));
            end else begin
               item.candidate = 16'($urandom_range(0, 65535));
            end
            item.run_end = ($urandom_range(0, 7) == 0);
            offer_candidate(item);
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d candidates in ascending runs, broken runs and noise.", sent_count);
      $display("Checked %0d results, %0d of them chain overflows.", result_count,
               overflow_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
